// ----- design/stsrch_pkg.sv -----
// Package for the sorted table search block.
// Holds table sizing, mode and status codes. No dependencies.
package stsrch_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int POS_W       = 11;
  localparam int ST_W        = 2;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_EXACT  = 2'd1;
  localparam logic [1:0] MODE_LOWER  = 2'd2;
  localparam logic [1:0] MODE_UPPER  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

endpackage

// ----- design/stsrch_if.sv -----
// Channel interfaces for the sorted table search block: query/append
// input channel and result channel. Depends on stsrch_pkg.
interface stsrch_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic signed [stsrch_pkg::KEY_W-1:0] key;
  logic                              restart;

  modport source (output valid, output mode, output key, output restart, input ready);
  modport sink   (input valid, input mode, input key, input restart, output ready);
endinterface

interface stsrch_out_if;
  logic                           valid;
  logic                           ready;
  logic [stsrch_pkg::POS_W-1:0]   position;
  logic [stsrch_pkg::ST_W-1:0]    status;

  modport source (output valid, output position, output status, input ready);
  modport sink   (input valid, input position, input status, output ready);
endinterface

// ----- design/stsrch_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module stsrch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/sorted_table_search.sv -----
// Top level of the sorted table search block: key table in a RAM, entry
// counter and the binary search sequencer. Depends on stsrch_pkg,
// stsrch_if and stsrch_ram.
//
// The block keeps up to TABLE_DEPTH signed keys, which the user must append
// in ascending order (the block does not check this), and answers exact,
// lower-bound and upper-bound queries by binary search. One item is worked
// on at a time. An append writes the key and then presents its result. A
// search makes one probe per halving of the range; each probe is a
// registered read of the key RAM followed by a compare. A finished result
// sits in the output register, and the next item is accepted while it waits
// to be taken.
module sorted_table_search (
  input  logic                clk,
  input  logic                rst_n,
  stsrch_in_if.sink           in_chan,
  stsrch_out_if.source        out_chan
);
  import stsrch_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

  state_t                  state_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        lo_r;
  logic [CNT_W-1:0]        end_r;
  logic [CNT_W-1:0]        mid_r;
  logic [1:0]              mode_r;
  logic signed [KEY_W-1:0] key_r;
  logic [POS_W-1:0]        res_pos_r;
  logic [ST_W-1:0]         res_st_r;
  logic                    out_valid_r;
  logic [POS_W-1:0]        out_pos_r;
  logic [ST_W-1:0]         out_st_r;

  logic                    in_xfer;
  logic                    out_free;
  logic [CNT_W-1:0]        cnt_eff;
  logic                    tbl_full;
  logic                    app_we;
  logic [CNT_W-1:0]        span;
  logic [CNT_W-1:0]        half;
  logic [CNT_W-1:0]        mid_nxt;
  logic [KEY_W-1:0]        rd_data;
  logic signed [KEY_W-1:0] entry;
  logic                    hit;
  logic                    go_right;

  assign in_chan.ready   = (state_r == S_IDLE);
  assign in_xfer         = in_chan.valid && in_chan.ready;
  assign out_free        = !out_valid_r || out_chan.ready;

  assign out_chan.valid    = out_valid_r;
  assign out_chan.position = out_pos_r;
  assign out_chan.status   = out_st_r;

  // Append path: restart empties the table before the write
  assign cnt_eff  = in_chan.restart ? '0 : count_r;
  assign tbl_full = (cnt_eff >= CNT_W'(TABLE_DEPTH));
  assign app_we   = in_xfer && (in_chan.mode == MODE_APPEND) && !tbl_full;

  // Exact search picks the lower middle entry, so for an even span its midpoint sits one lower
  assign span    = end_r - lo_r;
  assign half    = (mode_r == MODE_EXACT) ? ((span - CNT_W'(1)) >> 1) : (span >> 1);
  assign mid_nxt = lo_r + half;

  assign entry    = $signed(rd_data);
  assign hit      = (entry == key_r);
  assign go_right = (mode_r == MODE_UPPER) ? (entry <= key_r) : (entry < key_r);

  stsrch_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (app_we),
    .waddr (cnt_eff[IDX_W-1:0]),
    .wdata (in_chan.key),
    .raddr (mid_nxt[IDX_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            mode_r <= in_chan.mode;
            key_r  <= in_chan.key;
            lo_r   <= '0;
            end_r  <= count_r;
            if (in_chan.mode == MODE_APPEND) begin
              res_pos_r <= POS_W'(cnt_eff);
              if (tbl_full) begin
                res_st_r <= ST_FULL;
                count_r  <= cnt_eff;
              end else begin
                res_st_r <= ST_OK;
                count_r  <= cnt_eff + CNT_W'(1);
              end
              state_r <= S_DONE;
            end else begin
              state_r <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (lo_r < end_r) begin
            // read of entry mid is in flight
            mid_r   <= mid_nxt;
            state_r <= S_CMP;
          end else begin
            if (mode_r == MODE_EXACT) begin
              res_pos_r <= '0;
              res_st_r  <= ST_NOT_FOUND;
            end else begin
              res_pos_r <= POS_W'(lo_r);
              res_st_r  <= ST_OK;
            end
            state_r <= S_DONE;
          end
        end
        S_CMP: begin
          if ((mode_r == MODE_EXACT) && hit) begin
            res_pos_r <= POS_W'(mid_r);
            res_st_r  <= ST_OK;
            state_r   <= S_DONE;
          end else begin
            if (go_right) begin
              lo_r <= mid_r + CNT_W'(1);
            end else begin
              end_r <= mid_r;
            end
            state_r <= S_PROBE;
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (out_free) begin
            out_pos_r   <= res_pos_r;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
